// ===== src/iwt_pkg.sv =====
package iwt_pkg;

	localparam int RING_DEPTH_DEF = 256;

	localparam int IDX_W   = 64;
	localparam int SIZE_W  = 32;
	localparam int ME_W    = 9;
	localparam int BYTES_W = 48;
	localparam int CNT_O_W = 9;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	localparam logic [PADDR_W-1:0] ADDR_MAX_ENTRIES = 4'h0;
	localparam logic [PADDR_W-1:0] ADDR_MAX_BYTES   = 4'h8;

	localparam logic [ME_W-1:0] MAX_ENTRIES_RST = 9'd256;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] size;
	} entry_t;

endpackage

// ===== src/iwt_if.sv =====
interface iwt_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   operation;
	logic [iwt_pkg::IDX_W-1:0]    msg_index;
	logic [iwt_pkg::SIZE_W-1:0]   msg_bytes;

	modport source (output valid, output operation, output msg_index, output msg_bytes,
		input ready);
	modport sink (input valid, input operation, input msg_index, input msg_bytes,
		output ready);
endinterface

interface iwt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic                          window_full;
	logic [iwt_pkg::CNT_O_W-1:0]   entry_count;
	logic [iwt_pkg::BYTES_W-1:0]   bytes_in_flight;
	logic [iwt_pkg::CNT_O_W-1:0]   freed_count;

	modport source (output valid, output status, output window_full, output entry_count,
		output bytes_in_flight, output freed_count, input ready);
	modport sink (input valid, input status, input window_full, input entry_count,
		input bytes_in_flight, input freed_count, output ready);
endinterface

// ===== src/inflight_window_tracker.sv =====
// Channel | Dir | Fields
// req     | in  | operation, msg_index, msg_bytes
// rsp     | out | status, window_full, entry_count, bytes_in_flight, freed_count
// apb     | in  | max_entries @ 0x0, max_window_bytes @ 0x8 (64-bit data)
//
// Add, reset and unknown operations pass from S_IDLE through S_EXEC to S_DONE.
// Free adds S_FREE between S_EXEC and S_DONE, which releases the entries in turn with one
// ring read and one pass of the shared 48-bit add/subtract unit per entry.
// arst_n clears the window and the registers to their reset values.
// A stalled rsp holds the next result in its final step; req is taken only when idle.
module inflight_window_tracker #(
	parameter int RING_DEPTH = iwt_pkg::RING_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	iwt_req_if.sink                           req,
	iwt_rsp_if.source                         rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [iwt_pkg::PADDR_W-1:0]       paddr,
	input  logic [iwt_pkg::PDATA_W-1:0]       pwdata,
	output logic [iwt_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int BW = iwt_pkg::BYTES_W;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FREE, S_DONE} state_t;

	state_t                          state_q;
	logic [1:0]                      op_q;
	logic [iwt_pkg::IDX_W-1:0]       idx_q;
	logic [iwt_pkg::SIZE_W-1:0]      bytes_q;
	logic                            status_q;
	logic [CW-1:0]                   freed_q;
	logic [PW-1:0]                   start_q;
	logic [CW-1:0]                   count_q;
	logic [BW-1:0]                   total_q;
	logic [iwt_pkg::ME_W-1:0]        max_entries_q;
	logic [BW-1:0]                   max_bytes_q;

	logic                            out_valid_q;
	logic                            out_status_q;
	logic                            out_full_q;
	logic [iwt_pkg::CNT_O_W-1:0]     out_count_q;
	logic [BW-1:0]                   out_bytes_q;
	logic [iwt_pkg::CNT_O_W-1:0]     out_freed_q;

	logic [CW-1:0]                   cap;
	logic                            full;
	logic [SW-1:0]                   pos_sum;
	logic [PW-1:0]                   wr_pos;
	logic [PW-1:0]                   start_nxt;
	logic                            wr_en;
	logic [PW-1:0]                   rd_addr;
	iwt_pkg::entry_t                 wr_data;
	iwt_pkg::entry_t                 rd_data;
	logic                            alu_sub;
	logic [BW-1:0]                   alu_b;
	logic [BW-1:0]                   alu_y;
	logic                            free_step;
	logic                            cfg_wr;

	always_comb begin
		if (max_entries_q == '0) begin
			cap = CW'(1);
		end else if (32'(max_entries_q) > 32'(RING_DEPTH)) begin
			cap = CW'(RING_DEPTH);
		end else begin
			cap = CW'(max_entries_q);
		end
	end

	assign full = (count_q >= cap) || ((max_bytes_q != '0) && (total_q >= max_bytes_q));

	assign pos_sum = SW'(start_q) + SW'(count_q);
	assign wr_pos  = (pos_sum >= SW'(RING_DEPTH)) ? PW'(pos_sum - SW'(RING_DEPTH))
		: PW'(pos_sum);
	assign start_nxt = (start_q == PW'(RING_DEPTH - 1)) ? '0 : start_q + 1'b1;

	assign wr_en        = (state_q == S_EXEC) && (op_q == iwt_pkg::OP_ADD) && !full;
	assign wr_data.idx  = idx_q;
	assign wr_data.size = bytes_q;
	assign rd_addr      = (state_q == S_FREE) ? start_nxt : start_q;

	assign free_step = (count_q != '0) && (rd_data.idx <= idx_q);

	// shared byte-total adder
	assign alu_sub = (state_q == S_FREE);
	assign alu_b   = alu_sub ? BW'(rd_data.size) : BW'(bytes_q);
	assign alu_y   = alu_sub ? total_q - alu_b : total_q + alu_b;

	iwt_ring #(
		.RING_DEPTH (RING_DEPTH),
		.PW         (PW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_pos),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			iwt_pkg::ADDR_MAX_ENTRIES: prdata = iwt_pkg::PDATA_W'(max_entries_q);
			iwt_pkg::ADDR_MAX_BYTES:   prdata = iwt_pkg::PDATA_W'(max_bytes_q);
			default:                   prdata = '0;
		endcase
	end

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.window_full     = out_full_q;
	assign rsp.entry_count     = out_count_q;
	assign rsp.bytes_in_flight = out_bytes_q;
	assign rsp.freed_count     = out_freed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= iwt_pkg::OP_ADD;
			idx_q         <= '0;
			bytes_q       <= '0;
			status_q      <= iwt_pkg::STATUS_OK;
			freed_q       <= '0;
			start_q       <= '0;
			count_q       <= '0;
			total_q       <= '0;
			max_entries_q <= iwt_pkg::MAX_ENTRIES_RST;
			max_bytes_q   <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= iwt_pkg::STATUS_OK;
			out_full_q    <= 1'b0;
			out_count_q   <= '0;
			out_bytes_q   <= '0;
			out_freed_q   <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr == iwt_pkg::ADDR_MAX_ENTRIES) begin
					max_entries_q <= pwdata[iwt_pkg::ME_W-1:0];
				end
				if (paddr == iwt_pkg::ADDR_MAX_BYTES) begin
					max_bytes_q <= pwdata[BW-1:0];
				end
			end

			if (rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.operation;
						idx_q    <= req.msg_index;
						bytes_q  <= req.msg_bytes;
						status_q <= iwt_pkg::STATUS_OK;
						freed_q  <= '0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						iwt_pkg::OP_ADD: begin
							if (full) begin
								status_q <= iwt_pkg::STATUS_FULL;
							end else begin
								count_q <= count_q + 1'b1;
								total_q <= alu_y;
							end
							state_q <= S_DONE;
						end
						iwt_pkg::OP_FREE: begin
							state_q <= S_FREE;
						end
						iwt_pkg::OP_RESET: begin
							count_q <= '0;
							start_q <= '0;
							total_q <= '0;
							state_q <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_FREE: begin
					if (free_step) begin
						total_q <= alu_y;
						count_q <= count_q - 1'b1;
						freed_q <= freed_q + 1'b1;
						start_q <= start_nxt;
					end else begin
						if (count_q == '0) begin
							start_q <= '0;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_full_q   <= full;
						out_count_q  <= iwt_pkg::CNT_O_W'(count_q);
						out_bytes_q  <= total_q;
						out_freed_q  <= iwt_pkg::CNT_O_W'(freed_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/iwt_ring.sv =====
module iwt_ring #(
	parameter int RING_DEPTH = iwt_pkg::RING_DEPTH_DEF,
	parameter int PW = 8
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [PW-1:0]         wr_addr,
	input  iwt_pkg::entry_t       wr_data,
	input  logic [PW-1:0]         rd_addr,
	output iwt_pkg::entry_t       rd_data
);

	iwt_pkg::entry_t mem_q [RING_DEPTH];
	iwt_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== bench/testbench.sv =====
module testbench;

	localparam int RING = iwt_pkg::RING_DEPTH_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 270;
	localparam logic [iwt_pkg::IDX_W-1:0] IDX_ALL = {iwt_pkg::IDX_W{1'b1}};
	localparam logic [iwt_pkg::SIZE_W-1:0] SIZE_ALL = {iwt_pkg::SIZE_W{1'b1}};
	localparam logic [iwt_pkg::BYTES_W-1:0] BYTES_ALL = {iwt_pkg::BYTES_W{1'b1}};

	typedef struct packed {
		logic [1:0]                 op;
		logic [iwt_pkg::IDX_W-1:0]  idx;
		logic [iwt_pkg::SIZE_W-1:0] size;
	} window_req_t;

	typedef struct packed {
		logic                        status;
		logic                        full;
		logic [iwt_pkg::CNT_O_W-1:0] count;
		logic [iwt_pkg::BYTES_W-1:0] bytes;
		logic [iwt_pkg::CNT_O_W-1:0] freed;
	} window_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [iwt_pkg::PADDR_W-1:0] paddr = '0;
	logic [iwt_pkg::PDATA_W-1:0] pwdata = '0;
	logic [iwt_pkg::PDATA_W-1:0] prdata;
	logic pready;

	iwt_req_if req_ch();
	iwt_rsp_if rsp_ch();

	inflight_window_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	window_req_t ops_to_send[$];
	window_result_t pending_reports[$];
	window_req_t cur_req;
	window_result_t want_report;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int quiet = 0;
	logic [iwt_pkg::IDX_W-1:0] next_seq;
	logic [iwt_pkg::IDX_W-1:0] oldest_seq;

	logic [iwt_pkg::IDX_W-1:0] win_idx [RING];
	logic [iwt_pkg::SIZE_W-1:0] win_size [RING];
	int win_head = 0;
	int win_live = 0;
	logic [iwt_pkg::BYTES_W-1:0] win_bytes = '0;
	logic [iwt_pkg::ME_W-1:0] cap_reg = iwt_pkg::MAX_ENTRIES_RST;
	logic [iwt_pkg::BYTES_W-1:0] limit_reg = '0;

	function automatic logic window_full_now();
		int cap;
		cap = (cap_reg == 0) ? 1 : ((cap_reg > RING) ? RING : int'(cap_reg));
		return (win_live >= cap) || (limit_reg != 0 && win_bytes >= limit_reg);
	endfunction

	function automatic window_result_t track_window(window_req_t r);
		window_result_t res;
		int p;
		int freed;
		logic [iwt_pkg::BYTES_W-1:0] released;
		res = '0;
		res.status = iwt_pkg::STATUS_OK;
		freed = 0;
		released = '0;
		case (r.op)
			iwt_pkg::OP_ADD: begin
				if (window_full_now()) begin
					res.status = iwt_pkg::STATUS_FULL;
				end else begin
					p = (win_head + win_live) % RING;
					win_idx[p] = r.idx;
					win_size[p] = r.size;
					win_live++;
					win_bytes = win_bytes + r.size;
				end
			end
			iwt_pkg::OP_FREE: begin
				p = win_head;
				while (freed < win_live && win_idx[p] <= r.idx) begin
					released = released + win_size[p];
					p = (p + 1) % RING;
					freed++;
				end
				win_live -= freed;
				win_bytes = win_bytes - released;
				win_head = (win_live == 0) ? 0 : p;
			end
			iwt_pkg::OP_RESET: begin
				win_live = 0;
				win_head = 0;
				win_bytes = '0;
			end
			default: begin
			end
		endcase
		res.full = window_full_now();
		res.count = iwt_pkg::CNT_O_W'(win_live);
		res.bytes = win_bytes;
		res.freed = iwt_pkg::CNT_O_W'(freed);
		return res;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= iwt_pkg::OP_ADD;
			req_ch.msg_index <= '0;
			req_ch.msg_bytes <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (ops_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cur_req = ops_to_send.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.operation <= cur_req.op;
				req_ch.msg_index <= cur_req.idx;
				req_ch.msg_bytes <= cur_req.size;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				pending_reports.push_back(track_window({req_ch.operation, req_ch.msg_index,
					req_ch.msg_bytes}));
			if (psel && penable && pwrite && pready) begin
				if (paddr == iwt_pkg::ADDR_MAX_ENTRIES)
					cap_reg = pwdata[iwt_pkg::ME_W-1:0];
				else if (paddr == iwt_pkg::ADDR_MAX_BYTES)
					limit_reg = pwdata[iwt_pkg::BYTES_W-1:0];
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				mismatches++;
			end else begin
				want_report = pending_reports.pop_front();
				check_field("status", want_report.status, rsp_ch.status);
				check_field("window_full", want_report.full, rsp_ch.window_full);
				check_field("entry_count", want_report.count, rsp_ch.entry_count);
				check_field("bytes_in_flight", want_report.bytes, rsp_ch.bytes_in_flight);
				check_field("freed_count", want_report.freed, rsp_ch.freed_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet <= 0;
			end else if (quiet + 1 >= QUIET_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic queue_op(logic [1:0] op, logic [iwt_pkg::IDX_W-1:0] idx,
		logic [iwt_pkg::SIZE_W-1:0] size);
		window_req_t r;
		r.op = op;
		r.idx = idx;
		r.size = size;
		ops_to_send.push_back(r);
	endtask

	task automatic wait_idle();
		while (ops_to_send.size() != 0 || req_ch.valid || pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_reg(logic [iwt_pkg::PADDR_W-1:0] addr,
		logic [iwt_pkg::PDATA_W-1:0] value);
		wait_idle();
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic queue_random(int n, int add_pct, bit wide_sizes);
		int roll;
		int pick;
		logic [iwt_pkg::IDX_W-1:0] bound;
		logic [iwt_pkg::SIZE_W-1:0] size;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				// noise: arbitrary indexes and the unused code
				case ($urandom_range(0, 2))
					0: queue_op(iwt_pkg::OP_ADD, {$urandom, $urandom}, $urandom);
					1: queue_op(iwt_pkg::OP_FREE, {$urandom, $urandom}, $urandom);
					default: queue_op(OP_UNUSED, {$urandom, $urandom}, $urandom);
				endcase
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					queue_op(iwt_pkg::OP_RESET, {$urandom, $urandom}, $urandom);
					oldest_seq = next_seq;
				end else if (roll < 3 + add_pct) begin
					if (wide_sizes)
						size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
					else
						size = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000);
					queue_op(iwt_pkg::OP_ADD, next_seq, size);
					next_seq = next_seq + 1 +
						(($urandom_range(0, 7) == 0) ? $urandom_range(1, 1000) : 0);
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 10)
						bound = next_seq;
					else if (pick < 20)
						bound = oldest_seq - 1;
					else
						bound = oldest_seq + $urandom_range(0, 3);
					queue_op(iwt_pkg::OP_FREE, bound, $urandom);
					if (bound >= oldest_seq)
						oldest_seq = bound + 1;
				end
			end
		end
	endtask

	task automatic run_phase(logic [iwt_pkg::ME_W-1:0] cap, logic [iwt_pkg::BYTES_W-1:0] limit,
		int n, int add_pct, bit wide_sizes);
		program_reg(iwt_pkg::ADDR_MAX_ENTRIES, iwt_pkg::PDATA_W'(cap));
		program_reg(iwt_pkg::ADDR_MAX_BYTES, iwt_pkg::PDATA_W'(limit));
		queue_op(iwt_pkg::OP_RESET, '0, '0);
		next_seq = {$urandom, $urandom};
		oldest_seq = next_seq;
		queue_random(n, add_pct, wide_sizes);
	endtask

	initial begin
		send_idle_pct = 10;
		recv_idle_pct = 48;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		queue_op(iwt_pkg::OP_FREE, IDX_ALL, '0);
		queue_op(iwt_pkg::OP_ADD, '0, '0);
		queue_op(iwt_pkg::OP_ADD, IDX_ALL, SIZE_ALL);
		queue_op(iwt_pkg::OP_ADD, 64'd5, 32'd100);
		queue_op(iwt_pkg::OP_FREE, '0, SIZE_ALL);
		queue_op(OP_UNUSED, IDX_ALL, SIZE_ALL);
		queue_op(iwt_pkg::OP_FREE, 64'd4, '0);
		queue_op(iwt_pkg::OP_FREE, IDX_ALL, '0);
		queue_op(iwt_pkg::OP_ADD, 64'd10, 32'd10);
		queue_op(iwt_pkg::OP_ADD, 64'd11, 32'd11);
		queue_op(iwt_pkg::OP_ADD, 64'd12, 32'd12);
		queue_op(iwt_pkg::OP_RESET, IDX_ALL, SIZE_ALL);
		queue_op(iwt_pkg::OP_ADD, 64'd20, 32'd7);
		queue_op(iwt_pkg::OP_ADD, 64'd21, 32'd7);
		queue_op(iwt_pkg::OP_ADD, 64'd22, 32'd7);
		// shrink capacity below the live count
		program_reg(iwt_pkg::ADDR_MAX_ENTRIES, 64'd2);
		queue_op(iwt_pkg::OP_ADD, 64'd23, 32'd7);
		queue_op(iwt_pkg::OP_FREE, 64'd21, '0);
		queue_op(iwt_pkg::OP_ADD, 64'd23, 32'd7);
		queue_op(iwt_pkg::OP_ADD, 64'd24, 32'd7);
		program_reg(iwt_pkg::ADDR_MAX_ENTRIES, 64'd0);
		queue_op(iwt_pkg::OP_FREE, IDX_ALL, '0);
		queue_op(iwt_pkg::OP_ADD, 64'd30, 32'd7);
		queue_op(iwt_pkg::OP_ADD, 64'd31, 32'd7);
		program_reg(iwt_pkg::ADDR_MAX_ENTRIES, 64'd256);
		program_reg(iwt_pkg::ADDR_MAX_BYTES, 64'd1);
		queue_op(iwt_pkg::OP_FREE, IDX_ALL, '0);
		queue_op(iwt_pkg::OP_ADD, 64'd40, 32'd0);
		queue_op(iwt_pkg::OP_ADD, 64'd41, 32'd1);
		queue_op(iwt_pkg::OP_ADD, 64'd42, 32'd5);
		queue_op(iwt_pkg::OP_RESET, '0, '0);

		run_phase(9'd256, '0, 300, 55, 1'b0);
		hold_req++;
		run_phase(9'd4, '0, 200, 55, 1'b0);

		wait_idle();
		send_idle_pct = 48;
		recv_idle_pct = 10;
		run_phase(9'd17, 48'd20000, 200, 55, 1'b0);
		run_phase(9'd511, BYTES_ALL, 350, 80, 1'b1);

		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(9'd1, 48'd3000, 150, 50, 1'b0);
		run_phase(9'd256, '0, 200, 55, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

// ===== files.f =====
src/iwt_pkg.sv
src/iwt_if.sv
src/iwt_ring.sv
src/inflight_window_tracker.sv
bench/testbench.sv
